@@ rtl/bra_pkg.sv @@
`timescale 1ns / 1ps
package bra_pkg;
    localparam int COORD_WIDTH_DEF     = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 7;
    localparam int CORDIC_STAGES_DEF   = 16;
    localparam int ZFRAC               = 24;
    localparam int MAX_STAGES          = 24;
    localparam int ZW                  = 36;

    typedef enum logic [2:0] {
        AZ_CORDIC,
        AZ_ZERO,
        AZ_RIGHT,
        AZ_DOWN,
        AZ_LEFT
    } az_kind_t;

    typedef struct packed {
        az_kind_t kind;
        logic     neg_x;
        logic     neg_y;
    } az_ctl_t;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = ZW'(754974720);
            1:  r = ZW'(445687602);
            2:  r = ZW'(235489088);
            3:  r = ZW'(119537938);
            4:  r = ZW'(60000934);
            5:  r = ZW'(30029717);
            6:  r = ZW'(15018523);
            7:  r = ZW'(7509720);
            8:  r = ZW'(3754917);
            9:  r = ZW'(1877466);
            10: r = ZW'(938734);
            11: r = ZW'(469367);
            12: r = ZW'(234684);
            13: r = ZW'(117342);
            14: r = ZW'(58671);
            15: r = ZW'(29335);
            16: r = ZW'(14668);
            17: r = ZW'(7334);
            18: r = ZW'(3667);
            19: r = ZW'(1833);
            20: r = ZW'(917);
            21: r = ZW'(458);
            22: r = ZW'(229);
            23: r = ZW'(115);
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

@@ rtl/bearing_rotation_angle_top.sv @@
`timescale 1ns / 1ps
// Bearing and turn-angle unit. Each input word holds start, present and goal
// points; each output word gives the turn angle and the two azimuths (start to
// present, present to goal) in 1/2^ANGLE_FRAC_BITS degree, clockwise from +Y.
// Both arctangents run through one chain of CORDIC_STAGES cells (at most MAX_STAGES), so a new word
// is taken every cycle unless the chain stalls; each word passes the cell registers, the azimuth register and the
// output register. The chain stalls as a whole when the output register is full and not being taken.
module bearing_rotation_angle_top #(
    parameter int COORD_WIDTH     = bra_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = bra_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = bra_pkg::CORDIC_STAGES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // start_x, start_y, here_x, here_y, goal_x, goal_y
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // turn_angle, heading_now, bearing_goal
    output logic [47:0]                m_tdata
);
    import bra_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int VW   = DW + ZFRAC + 2;
    localparam int SW   = 2 * $bits(az_ctl_t);
    localparam int NST  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
    localparam int SH   = ZFRAC - ANGLE_FRAC_BITS;
    localparam int AW   = ANGLE_FRAC_BITS + 11;
    localparam int DFW  = AW + 2;
    localparam logic signed [ZW-1:0] ZLIM = ZW'(90) <<< ZFRAC;
    localparam logic [AW-1:0] D90  = AW'(90) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] D180 = AW'(180) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] D270 = AW'(270) << ANGLE_FRAC_BITS;
    localparam logic [AW-1:0] D360 = AW'(360) << ANGLE_FRAC_BITS;

    logic en;
    logic out_v_reg;
    logic [47:0] out_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    // stage 0: deltas and classification
    logic signed [COORD_WIDTH-1:0] cf [6];
    logic signed [DW-1:0] dx [2];
    logic signed [DW-1:0] dy [2];
    az_ctl_t ctl [2];
    logic signed [VW-1:0] x0 [2];
    logic signed [VW-1:0] y0 [2];
    logic signed [ZW-1:0] z0 [2];

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            cf[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
        dx[0] = DW'(cf[2]) - DW'(cf[0]);
        dy[0] = DW'(cf[3]) - DW'(cf[1]);
        dx[1] = DW'(cf[4]) - DW'(cf[2]);
        dy[1] = DW'(cf[5]) - DW'(cf[3]);
        for (int c = 0; c < 2; c++)
        begin
            ctl[c].neg_x = dx[c][DW-1];
            ctl[c].neg_y = dy[c][DW-1];
            if (dx[c] == '0 && (dy[c] == '0 || !dy[c][DW-1]))
                ctl[c].kind = AZ_ZERO;
            else if (dx[c] == '0)
                ctl[c].kind = AZ_DOWN;
            else if (dy[c] == '0)
                ctl[c].kind = dx[c][DW-1] ? AZ_LEFT : AZ_RIGHT;
            else
                ctl[c].kind = AZ_CORDIC;
            // x takes |dy|, y takes |dx|
            x0[c] = VW'(dy[c][DW-1] ? -dy[c] : dy[c]) <<< ZFRAC;
            y0[c] = VW'(dx[c][DW-1] ? -dx[c] : dx[c]) <<< ZFRAC;
            z0[c] = '0;
        end
    end

    logic                 v_ch [NST+1];
    logic signed [VW-1:0] x_ch [NST+1][2];
    logic signed [VW-1:0] y_ch [NST+1][2];
    logic signed [ZW-1:0] z_ch [NST+1][2];
    logic [SW-1:0]        s_ch [NST+1];

    always_comb
    begin
        v_ch[0] = s_tvalid;
        x_ch[0] = x0;
        y_ch[0] = y0;
        z_ch[0] = z0;
        s_ch[0] = {ctl[1], ctl[0]};
    end

    for (genvar g = 0; g < NST; g++)
    begin : g_cell
        bra_cell #(.VW(VW), .SW(SW), .STAGE(g)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .vin(v_ch[g]), .x_in(x_ch[g]), .y_in(y_ch[g]), .z_in(z_ch[g]),
            .side_in(s_ch[g]),
            .vout(v_ch[g+1]), .x_out(x_ch[g+1]), .y_out(y_ch[g+1]),
            .z_out(z_ch[g+1]), .side_out(s_ch[g+1])
        );
    end

    // clamp, round, quadrant map
    az_ctl_t ec [2];
    logic signed [ZW-1:0] zc [2];
    logic [AW-1:0] th [2];
    logic [AW-1:0] az_next [2];
    logic [AW-1:0] az_reg [2];
    logic az_v_reg;

    always_comb
    begin
        {ec[1], ec[0]} = s_ch[NST];
        for (int c = 0; c < 2; c++)
        begin
            zc[c] = z_ch[NST][c];
            if (zc[c][ZW-1])
                zc[c] = '0;
            else if (zc[c] > ZLIM)
                zc[c] = ZLIM;
            th[c] = AW'((zc[c] + (ZW'(1) <<< (SH - 1))) >>> SH);
            case (ec[c].kind)
                AZ_ZERO:  az_next[c] = '0;
                AZ_DOWN:  az_next[c] = D180;
                AZ_RIGHT: az_next[c] = D90;
                AZ_LEFT:  az_next[c] = D270;
                default:
                begin
                    if (!ec[c].neg_x && !ec[c].neg_y)
                        az_next[c] = th[c];
                    else if (!ec[c].neg_x)
                        az_next[c] = D180 - th[c];
                    else if (ec[c].neg_y)
                        az_next[c] = D180 + th[c];
                    else
                        az_next[c] = D360 - th[c];
                end
            endcase
            if (az_next[c] == D360)
                az_next[c] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            az_v_reg <= 1'b0;
        else if (en)
            az_v_reg <= v_ch[NST];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            az_reg <= az_next;
    end

    // turn angle and output register
    logic signed [DFW-1:0] diff;
    logic [47:0] out_next;

    always_comb
    begin
        diff = DFW'(az_reg[1]) - DFW'(az_reg[0]);
        if (diff > $signed(DFW'(D180)))
            diff = diff - DFW'(D360);
        else if (diff < -$signed(DFW'(D180)))
            diff = diff + DFW'(D360);
        out_next = {az_reg[1][15:0], az_reg[0][15:0], diff[15:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= az_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
endmodule

@@ rtl/bra_cell.sv @@
`timescale 1ns / 1ps
// One CORDIC vectoring step on both azimuth channels, plus carried side data.
module bra_cell #(
    parameter int VW    = 42,
    parameter int SW    = 8,
    parameter int STAGE = 0
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     vin,
    input  logic signed [VW-1:0]     x_in [2],
    input  logic signed [VW-1:0]     y_in [2],
    input  logic signed [bra_pkg::ZW-1:0] z_in [2],
    input  logic [SW-1:0]            side_in,
    output logic                     vout,
    output logic signed [VW-1:0]     x_out [2],
    output logic signed [VW-1:0]     y_out [2],
    output logic signed [bra_pkg::ZW-1:0] z_out [2],
    output logic [SW-1:0]            side_out
);
    import bra_pkg::*;

    logic signed [VW-1:0] x_reg [2];
    logic signed [VW-1:0] y_reg [2];
    logic signed [ZW-1:0] z_reg [2];
    logic signed [VW-1:0] x_next [2];
    logic signed [VW-1:0] y_next [2];
    logic signed [ZW-1:0] z_next [2];
    logic [SW-1:0]        side_reg;
    logic                 v_reg;

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            if (!y_in[c][VW-1])
            begin
                x_next[c] = x_in[c] + (y_in[c] >>> STAGE);
                y_next[c] = y_in[c] - (x_in[c] >>> STAGE);
                z_next[c] = z_in[c] + atan_entry(STAGE);
            end
            else
            begin
                x_next[c] = x_in[c] - (y_in[c] >>> STAGE);
                y_next[c] = y_in[c] + (x_in[c] >>> STAGE);
                z_next[c] = z_in[c] - atan_entry(STAGE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vout     = v_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;
endmodule
